// ===== src/ddpid_pkg.sv =====
// Shared types, widths and constants for the drive distance PID controller.
// No dependencies; imported by ddpid_core, the top level, ddpid_checker and the testbench.
package ddpid_pkg;

    localparam int GAIN_W     = 24;
    localparam int PCT_W      = 7;
    localparam int TMO_W      = 16;
    localparam int DPI_W      = 16;
    localparam int CFG_W      = 24;
    localparam int CFG_ADDR_W = 3;
    localparam int TIN_W      = 16;
    localparam int POS_W      = 20;
    localparam int TIME_W     = 32;
    localparam int POWER_W    = 8;
    localparam int IN_DATA_W  = 128;
    localparam int OUT_DATA_W = 16;

    localparam int TGT_W  = 18;   // target in quarter degrees
    localparam int PSUM_W = 22;   // sum of four wheel positions
    localparam int ERR_W  = 23;
    localparam int DERR_W = 24;
    localparam int ESUM_W = 40;

    localparam int SETTLE_SAMPLES_DEF = 3;

    localparam logic [GAIN_W-1:0] GAIN_P_RST = 24'd230687;
    localparam logic [GAIN_W-1:0] GAIN_I_RST = 24'd0;
    localparam logic [GAIN_W-1:0] GAIN_D_RST = 24'd104858;
    localparam logic [PCT_W-1:0]  PCT_RST    = 7'd100;
    localparam logic [TMO_W-1:0]  TMO_RST    = 16'd3000;
    localparam logic [DPI_W-1:0]  DPI_RST    = 16'd12035;

    localparam logic [PCT_W-1:0]  PCT_MAX   = 7'd100;
    localparam logic [TIME_W-1:0] MOVE_MS   = 32'd150;
    localparam logic signed [ERR_W-1:0]  ERR_THR_P  = 23'sd20;
    localparam logic signed [ERR_W-1:0]  ERR_THR_N  = -23'sd20;
    localparam logic signed [PSUM_W-1:0] PSUM_THR_P = 22'sd20;
    localparam logic signed [PSUM_W-1:0] PSUM_THR_N = -22'sd20;

    localparam logic CMD_START  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_GAIN_P = 3'd0,
        REG_GAIN_I = 3'd1,
        REG_GAIN_D = 3'd2,
        REG_PCT    = 3'd3,
        REG_TMO    = 3'd4,
        REG_DPI    = 3'd5
    } cfg_addr_t;

    typedef enum logic [1:0] {
        CAUSE_NONE    = 2'd0,
        CAUSE_SETTLED = 2'd1,
        CAUSE_TIMEOUT = 2'd2
    } cause_t;

    // item handed from the state stage to the arithmetic pipe
    typedef struct packed {
        logic                      calc;
        logic                      active;
        cause_t                    cause;
        logic signed [ERR_W-1:0]   err;
        logic signed [DERR_W-1:0]  derr;
        logic signed [ESUM_W-1:0]  esum;
    } ddpid_item_t;

    typedef struct packed {
        logic [GAIN_W-1:0] gain_p;
        logic [GAIN_W-1:0] gain_i;
        logic [GAIN_W-1:0] gain_d;
        logic [PCT_W-1:0]  max_pct;
    } ddpid_cfg_t;

endpackage

// ===== src/drive_distance_pid_with_settle_top.sv =====
// One item per cycle sustained while m_tready does not stall the result side.
// Stages: input, target/position sum, state update (error, integral, settle, timeout),
// then four arithmetic stages in ddpid_core; each stage holds while the next is full.
// Reset (rst_n, async low) loads default gains and limits, clears all move state
// and empties the pipe. Depends on ddpid_pkg and ddpid_core.
module drive_distance_pid_with_settle_top
    import ddpid_pkg::*;
#(
    parameter int SETTLE_SAMPLES = SETTLE_SAMPLES_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]      cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // target_inches[15:0], pos_back_left[35:16],
                                             // pos_front_left[55:36], pos_back_right[75:56],
                                             // pos_front_right[95:76], now_ms[127:96]
    input  logic                  s_tuser,   // cmd
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata    // motor_power[7:0], move_active[8], end_cause[10:9]
);

    localparam int CNT_W = $clog2(SETTLE_SAMPLES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(SETTLE_SAMPLES);

    // configuration registers
    logic [GAIN_W-1:0] gain_p_reg, gain_i_reg, gain_d_reg;
    logic [PCT_W-1:0]  max_pct_reg;
    logic [TMO_W-1:0]  tmo_reg;
    logic [DPI_W-1:0]  dpi_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg  <= GAIN_P_RST;
            gain_i_reg  <= GAIN_I_RST;
            gain_d_reg  <= GAIN_D_RST;
            max_pct_reg <= PCT_RST;
            tmo_reg     <= TMO_RST;
            dpi_reg     <= DPI_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_GAIN_P: gain_p_reg  <= cfg_wdata;
                REG_GAIN_I: gain_i_reg  <= cfg_wdata;
                REG_GAIN_D: gain_d_reg  <= cfg_wdata;
                REG_PCT:    max_pct_reg <= cfg_wdata[PCT_W-1:0];
                REG_TMO:    tmo_reg     <= cfg_wdata[TMO_W-1:0];
                REG_DPI:    dpi_reg     <= cfg_wdata[DPI_W-1:0];
                default:    ;
            endcase
        end
    end

    // pipe control
    logic a_valid_reg, b_valid_reg, c_valid_reg;
    logic en_a, en_b, en_c, core_ready;

    assign en_c     = !c_valid_reg || core_ready;
    assign en_b     = !b_valid_reg || en_c;
    assign en_a     = !a_valid_reg || en_b;
    assign s_tready = en_a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (en_a) a_valid_reg <= s_tvalid;
            if (en_b) b_valid_reg <= a_valid_reg;
            if (en_c) c_valid_reg <= b_valid_reg;
        end
    end

    // stage A: input register
    logic                     a_cmd_reg;
    logic signed [TIN_W-1:0]  a_tin_reg;
    logic signed [POS_W-1:0]  a_pos_reg [4];
    logic [TIME_W-1:0]        a_now_reg;

    // stage B: target and position sum
    logic signed [32:0]       tprod;
    logic signed [PSUM_W-1:0] psum_next;

    always_comb
    begin
        tprod     = {{17{a_tin_reg[TIN_W-1]}}, a_tin_reg} * $signed({17'b0, dpi_reg});
        psum_next = {{2{a_pos_reg[0][POS_W-1]}}, a_pos_reg[0]}
                  + {{2{a_pos_reg[1][POS_W-1]}}, a_pos_reg[1]}
                  + {{2{a_pos_reg[2][POS_W-1]}}, a_pos_reg[2]}
                  + {{2{a_pos_reg[3][POS_W-1]}}, a_pos_reg[3]};
    end

    logic                     b_cmd_reg;
    logic signed [TGT_W-1:0]  b_tgt_reg;
    logic signed [PSUM_W-1:0] b_psum_reg;
    logic [TIME_W-1:0]        b_now_reg;

    always_ff @(posedge clk)
    begin
        if (en_a)
        begin
            a_cmd_reg    <= s_tuser;
            a_tin_reg    <= s_tdata[15:0];
            a_pos_reg[0] <= s_tdata[35:16];
            a_pos_reg[1] <= s_tdata[55:36];
            a_pos_reg[2] <= s_tdata[75:56];
            a_pos_reg[3] <= s_tdata[95:76];
            a_now_reg    <= s_tdata[127:96];
        end
        if (en_b)
        begin
            b_cmd_reg  <= a_cmd_reg;
            b_tgt_reg  <= tprod[31:14];
            b_psum_reg <= psum_next;
            b_now_reg  <= a_now_reg;
        end
    end

    // move state
    logic signed [TGT_W-1:0]  target_reg;
    logic signed [ERR_W-1:0]  prev_err_reg;
    logic signed [ESUM_W-1:0] esum_reg;
    logic [TIME_W-1:0]        start_time_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic                     has_moved_reg;
    logic                     running_reg;

    // stage C: error, integral, settle and timeout
    logic signed [ERR_W-1:0]    err;
    logic signed [DERR_W-1:0]   derr;
    logic signed [ESUM_W:0]     esum_wide;
    logic signed [ESUM_W-1:0]   esum_sat;
    logic [TIME_W-1:0]          elapsed;
    logic                       err_small, moved_now, settled, settle_end, timeout, ended;
    logic                       is_sample;
    logic [CNT_W-1:0]           cnt_next;
    ddpid_item_t                item_next;

    always_comb
    begin
        is_sample = (b_cmd_reg == CMD_SAMPLE);
        err       = {{(ERR_W-TGT_W){target_reg[TGT_W-1]}}, target_reg}
                  - {b_psum_reg[PSUM_W-1], b_psum_reg};
        derr      = {err[ERR_W-1], err} - {prev_err_reg[ERR_W-1], prev_err_reg};
        elapsed   = b_now_reg - start_time_reg;
        err_small = (err < ERR_THR_P) && (err > ERR_THR_N);
        moved_now = has_moved_reg || (b_psum_reg > PSUM_THR_P) || (b_psum_reg < PSUM_THR_N)
                  || err_small || (elapsed > MOVE_MS);
        settled   = moved_now && err_small;
        if (!settled)
            cnt_next = '0;
        else if (cnt_reg == CNT_MAX)
            cnt_next = cnt_reg;
        else
            cnt_next = cnt_reg + 1'b1;
        settle_end = settled && (cnt_next >= CNT_MAX);
        timeout    = elapsed >= {16'b0, tmo_reg};
        ended      = settle_end || timeout;

        esum_wide = {esum_reg[ESUM_W-1], esum_reg}
                  + {{(ESUM_W+1-ERR_W){err[ERR_W-1]}}, err};
        if (esum_wide[ESUM_W] != esum_wide[ESUM_W-1])
            esum_sat = esum_wide[ESUM_W] ? {1'b1, {(ESUM_W-1){1'b0}}}
                                         : {1'b0, {(ESUM_W-1){1'b1}}};
        else
            esum_sat = esum_wide[ESUM_W-1:0];

        item_next.calc   = is_sample && running_reg && !ended;
        item_next.active = !is_sample || (running_reg && !ended);
        if (is_sample && running_reg && settle_end)
            item_next.cause = CAUSE_SETTLED;
        else if (is_sample && running_reg && timeout)
            item_next.cause = CAUSE_TIMEOUT;
        else
            item_next.cause = CAUSE_NONE;
        item_next.err  = err;
        item_next.derr = derr;
        item_next.esum = esum_sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg     <= '0;
            prev_err_reg   <= '0;
            esum_reg       <= '0;
            start_time_reg <= '0;
            cnt_reg        <= '0;
            has_moved_reg  <= 1'b0;
            running_reg    <= 1'b0;
        end
        else if (b_valid_reg && en_c)
        begin
            if (!is_sample)
            begin
                target_reg     <= b_tgt_reg;
                prev_err_reg   <= '0;
                esum_reg       <= '0;
                start_time_reg <= b_now_reg;
                cnt_reg        <= '0;
                has_moved_reg  <= 1'b0;
                running_reg    <= 1'b1;
            end
            else if (running_reg)
            begin
                has_moved_reg <= moved_now;
                esum_reg      <= esum_sat;
                cnt_reg       <= cnt_next;
                if (ended)
                    running_reg <= 1'b0;
                else
                    prev_err_reg <= err;
            end
        end
    end

    ddpid_item_t c_item_reg;

    always_ff @(posedge clk)
    begin
        if (en_c)
            c_item_reg <= item_next;
    end

    ddpid_cfg_t core_cfg;

    assign core_cfg.gain_p  = gain_p_reg;
    assign core_cfg.gain_i  = gain_i_reg;
    assign core_cfg.gain_d  = gain_d_reg;
    assign core_cfg.max_pct = max_pct_reg;

    ddpid_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (core_cfg),
        .in_valid (c_valid_reg),
        .in_item  (c_item_reg),
        .in_ready (core_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    a_move_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(running_reg) |-> $past(b_valid_reg && en_c && b_cmd_reg == CMD_SAMPLE))
        else $error("move ended without a sample item");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_MAX)
        else $error("settle count out of range");

    a_power_active: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[7:0] != '0) |-> m_tdata[8])
        else $error("motor power while move inactive");

    a_cause_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[10:9] != CAUSE_NONE) |-> !m_tdata[8])
        else $error("end cause on an active item");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !a_valid_reg |-> s_tready)
        else $error("input stage empty but not ready");

endmodule

// ===== src/ddpid_core.sv =====
// PID arithmetic pipe: P, clamped I, D divided by 20, output clamp and truncation.
// Four stages with per-stage valid; depends on ddpid_pkg.
module ddpid_core
    import ddpid_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ddpid_cfg_t            cfg,
    input  logic                  in_valid,
    input  ddpid_item_t           in_item,
    output logic                  in_ready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata    // motor_power[7:0], move_active[8], end_cause[10:9]
);

    localparam logic [44:0] RECIP_Q20 = 45'd6710887;    // ceil(2^25 / 5)
    localparam logic [53:0] RECIP_T20 = 54'd107374183;  // ceil(2^29 / 5)
    localparam logic [27:0] RECIP_P   = 28'd10486;      // ceil(2^20 / 100)
    localparam logic signed [63:0] I_MAX = 64'sd209715200;
    localparam logic signed [63:0] I_MIN = -64'sd209715200;

    // derived limits, registered copies that follow the config registers
    logic [PCT_W-1:0] pct_reg;
    logic [13:0]      pct127_reg;
    logic [PCT_W-1:0] pmax_reg;
    logic [19:0]      gdq_reg;
    logic [4:0]       gdr_reg;
    logic [44:0]      gq_prod;
    logic [27:0]      pm_prod;
    logic [GAIN_W-1:0] gd_rem;

    always_comb
    begin
        gq_prod = 45'(cfg.gain_d[GAIN_W-1:2]) * RECIP_Q20;
        pm_prod = 28'(pct127_reg) * RECIP_P;
        gd_rem  = cfg.gain_d - (GAIN_W'(gdq_reg) * 24'd20);
    end

    always_ff @(posedge clk)
    begin
        pct_reg    <= (cfg.max_pct > PCT_MAX) ? PCT_MAX : cfg.max_pct;
        pct127_reg <= 14'(pct_reg) * 14'd127;
        pmax_reg   <= pm_prod[26:20];
        gdq_reg    <= gq_prod[44:25];
        gdr_reg    <= gd_rem[4:0];
    end

    // stage enables
    logic d_valid_reg, e_valid_reg, f_valid_reg, g_valid_reg;
    logic en_d, en_e, en_f, en_g;

    assign en_g     = !g_valid_reg || m_tready;
    assign en_f     = !f_valid_reg || en_g;
    assign en_e     = !e_valid_reg || en_f;
    assign en_d     = !d_valid_reg || en_e;
    assign in_ready = en_d;
    assign m_tvalid = g_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
            g_valid_reg <= 1'b0;
        end
        else
        begin
            if (en_d) d_valid_reg <= in_valid;
            if (en_e) e_valid_reg <= d_valid_reg;
            if (en_f) f_valid_reg <= e_valid_reg;
            if (en_g) g_valid_reg <= f_valid_reg;
        end
    end

    // stage D: products
    logic signed [46:0] err_x, gp_x, pterm_next;
    logic [DERR_W-1:0]  dmag_in;
    logic [43:0]        dq_next;
    logic [28:0]        dr_next;
    logic signed [43:0] hi_x, gi_x, ip_hi_next;
    logic [43:0]        ip_lo_next;

    always_comb
    begin
        err_x      = {{(47-ERR_W){in_item.err[ERR_W-1]}}, in_item.err};
        gp_x       = {23'b0, cfg.gain_p};
        pterm_next = err_x * gp_x;
        dmag_in    = in_item.derr[DERR_W-1] ? DERR_W'(-in_item.derr) : DERR_W'(in_item.derr);
        dq_next    = 44'(dmag_in) * 44'(gdq_reg);
        dr_next    = 29'(dmag_in) * 29'(gdr_reg);
        hi_x       = {{24{in_item.esum[ESUM_W-1]}}, in_item.esum[ESUM_W-1:20]};
        gi_x       = {20'b0, cfg.gain_i};
        ip_hi_next = hi_x * gi_x;
        ip_lo_next = 44'(in_item.esum[19:0]) * 44'(cfg.gain_i);
    end

    logic               d_calc_reg, d_active_reg, d_dneg_reg;
    cause_t             d_cause_reg;
    logic signed [46:0] d_pterm_reg;
    logic [43:0]        d_dq_reg;
    logic [28:0]        d_dr_reg;
    logic signed [43:0] d_ip_hi_reg;
    logic [43:0]        d_ip_lo_reg;

    // stage E: integral clamp and D divide
    logic signed [63:0] ifull;
    logic signed [28:0] iterm_next;
    logic [53:0]        ddiv_prod;
    logic [44:0]        dmag_next;

    always_comb
    begin
        ifull = $signed({d_ip_hi_reg, 20'b0}) + $signed({20'b0, d_ip_lo_reg});
        if (ifull > I_MAX)
            iterm_next = I_MAX[28:0];
        else if (ifull < I_MIN)
            iterm_next = I_MIN[28:0];
        else
            iterm_next = ifull[28:0];
        ddiv_prod = 54'(d_dr_reg[28:2]) * RECIP_T20;
        dmag_next = 45'(d_dq_reg) + 45'(ddiv_prod[53:29]);
    end

    logic               e_calc_reg, e_active_reg, e_dneg_reg;
    cause_t             e_cause_reg;
    logic signed [46:0] e_pterm_reg;
    logic signed [28:0] e_iterm_reg;
    logic [44:0]        e_dmag_reg;

    // stage F: sum of terms
    logic signed [48:0] dterm_x, total_next;

    always_comb
    begin
        dterm_x    = e_dneg_reg ? -$signed({4'b0, e_dmag_reg}) : $signed({4'b0, e_dmag_reg});
        total_next = {{2{e_pterm_reg[46]}}, e_pterm_reg}
                   + {{20{e_iterm_reg[28]}}, e_iterm_reg}
                   + dterm_x;
    end

    logic               f_calc_reg, f_active_reg;
    cause_t             f_cause_reg;
    logic signed [48:0] f_total_reg;

    // stage G: limit and truncation
    logic signed [55:0]    tx, t100, lim, nlim;
    logic signed [26:0]    q_tr;
    logic [POWER_W-1:0]    pmax8, power_next;

    always_comb
    begin
        tx    = {{7{f_total_reg[48]}}, f_total_reg};
        t100  = (tx <<< 6) + (tx <<< 5) + (tx <<< 2);
        lim   = $signed({20'b0, pct127_reg, 22'b0});
        nlim  = -lim;
        q_tr  = f_total_reg[48:22]
              + 27'(f_total_reg[48] && (f_total_reg[21:0] != '0));
        pmax8 = {1'b0, pmax_reg};
        if (!f_calc_reg)
            power_next = '0;
        else if (t100 > lim)
            power_next = pmax8;
        else if (t100 < nlim)
            power_next = -pmax8;
        else
            power_next = q_tr[POWER_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en_d)
        begin
            d_calc_reg   <= in_item.calc;
            d_active_reg <= in_item.active;
            d_cause_reg  <= in_item.cause;
            d_dneg_reg   <= in_item.derr[DERR_W-1];
            d_pterm_reg  <= pterm_next;
            d_dq_reg     <= dq_next;
            d_dr_reg     <= dr_next;
            d_ip_hi_reg  <= ip_hi_next;
            d_ip_lo_reg  <= ip_lo_next;
        end
        if (en_e)
        begin
            e_calc_reg   <= d_calc_reg;
            e_active_reg <= d_active_reg;
            e_cause_reg  <= d_cause_reg;
            e_dneg_reg   <= d_dneg_reg;
            e_pterm_reg  <= d_pterm_reg;
            e_iterm_reg  <= iterm_next;
            e_dmag_reg   <= dmag_next;
        end
        if (en_f)
        begin
            f_calc_reg   <= e_calc_reg;
            f_active_reg <= e_active_reg;
            f_cause_reg  <= e_cause_reg;
            f_total_reg  <= total_next;
        end
        if (en_g)
        begin
            m_tdata <= {5'b0, f_cause_reg, f_active_reg, power_next};
        end
    end

endmodule

// ===== test/ddpid_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the drive distance PID controller: follows register writes,
// predicts one motor command per accepted item and checks the result stream.
// Depends on ddpid_pkg.
module ddpid_checker
    import ddpid_pkg::*;
#(
    parameter int SETTLE_SAMPLES = SETTLE_SAMPLES_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]      cfg_wdata,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    output int                    fail_count,
    output int                    pending
);

    localparam longint ONE22     = 64'sd1 <<< 22;
    localparam longint ESUM_HI   = (64'sd1 <<< 39) - 1;
    localparam longint ESUM_LO   = -(64'sd1 <<< 39);
    localparam longint ITERM_LIM = 50 * ONE22;
    localparam longint NEAR_Q    = 20;

    typedef struct packed {
        logic [POWER_W-1:0] power;
        logic               active;
        cause_t             cause;
    } motor_cmd_t;

    logic [GAIN_W-1:0] gain_p;
    logic [GAIN_W-1:0] gain_i;
    logic [GAIN_W-1:0] gain_d;
    logic [PCT_W-1:0]  max_pct;
    logic [TMO_W-1:0]  tmo_ms;
    logic [DPI_W-1:0]  dpi;

    longint            tgt_qdeg;
    longint            prev_err;
    longint            err_acc;
    logic [TIME_W-1:0] t_start;
    int                settle_cnt;
    logic              moved;
    logic              in_move;

    motor_cmd_t motor_cmd_q[$];
    motor_cmd_t got;
    motor_cmd_t want;

    function automatic longint mag(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic motor_cmd_t compute_drive_cmd(
        input logic                    cmd,
        input logic signed [TIN_W-1:0] tin,
        input logic signed [POS_W-1:0] p0,
        input logic signed [POS_W-1:0] p1,
        input logic signed [POS_W-1:0] p2,
        input logic signed [POS_W-1:0] p3,
        input logic [TIME_W-1:0]       now
    );
        motor_cmd_t        r;
        longint            psum;
        longint            err;
        longint            pterm;
        longint            iterm;
        longint            dterm;
        longint            total;
        longint            pct;
        longint            lim;
        longint            pwr;
        logic [TIME_W-1:0] elapsed;
        logic              done;
        r.active = 1'b0;
        r.cause  = CAUSE_NONE;
        pwr      = 0;
        done     = 1'b0;
        if (cmd == CMD_START)
        begin
            tgt_qdeg   = (longint'(tin) * longint'(dpi)) >>> 14;
            prev_err   = 0;
            err_acc    = 0;
            settle_cnt = 0;
            moved      = 1'b0;
            t_start    = now;
            in_move    = 1'b1;
            r.active   = 1'b1;
        end
        else if (in_move)
        begin
            psum    = longint'(p0) + longint'(p1) + longint'(p2) + longint'(p3);
            err     = tgt_qdeg - psum;
            elapsed = now - t_start;
            pct     = (max_pct > PCT_MAX) ? 100 : longint'(max_pct);
            lim     = pct * 127 * ONE22;

            if (mag(psum) > NEAR_Q || mag(err) < NEAR_Q || elapsed > MOVE_MS)
                moved = 1'b1;

            pterm   = err * longint'(gain_p);
            err_acc = err_acc + err;
            if (err_acc > ESUM_HI)
                err_acc = ESUM_HI;
            if (err_acc < ESUM_LO)
                err_acc = ESUM_LO;
            iterm = err_acc * longint'(gain_i);
            if (iterm > ITERM_LIM)
                iterm = ITERM_LIM;
            if (iterm < -ITERM_LIM)
                iterm = -ITERM_LIM;
            dterm = ((err - prev_err) * longint'(gain_d)) / 20;
            total = pterm + iterm + dterm;

            if (total * 100 > lim)
                pwr = pct * 127 / 100;
            else if (total * 100 < -lim)
                pwr = -(pct * 127 / 100);
            else
                pwr = total / ONE22;

            if (moved && mag(err) < NEAR_Q)
            begin
                if (settle_cnt < 255)
                    settle_cnt++;
                if (settle_cnt >= SETTLE_SAMPLES)
                begin
                    done    = 1'b1;
                    r.cause = CAUSE_SETTLED;
                end
            end
            else
                settle_cnt = 0;

            if (!done && elapsed >= tmo_ms)
            begin
                done    = 1'b1;
                r.cause = CAUSE_TIMEOUT;
            end

            if (done)
            begin
                in_move = 1'b0;
                pwr     = 0;
            end
            else
            begin
                prev_err = err;
                r.active = 1'b1;
            end
        end
        r.power = pwr[POWER_W-1:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p     = GAIN_P_RST;
            gain_i     = GAIN_I_RST;
            gain_d     = GAIN_D_RST;
            max_pct    = PCT_RST;
            tmo_ms     = TMO_RST;
            dpi        = DPI_RST;
            tgt_qdeg   = 0;
            prev_err   = 0;
            err_acc    = 0;
            t_start    = '0;
            settle_cnt = 0;
            moved      = 1'b0;
            in_move    = 1'b0;
            motor_cmd_q.delete();
            pending    = 0;
            fail_count = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.power  = m_tdata[7:0];
                got.active = m_tdata[8];
                got.cause  = cause_t'(m_tdata[10:9]);
                if (motor_cmd_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected item: power %0d active %0b cause %0d",
                                 $time, $signed(got.power), got.active, got.cause);
                end
                else
                begin
                    want = motor_cmd_q.pop_front();
                    if (got.power !== want.power || got.active !== want.active
                        || got.cause !== want.cause)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $write("%0t: mismatch: expected power %0d active %0b cause %0d, ",
                                   $time, $signed(want.power), want.active, want.cause);
                            $display("got power %0d active %0b cause %0d",
                                     $signed(got.power), got.active, got.cause);
                        end
                    end
                end
            end

            if (cfg_we)
            begin
                case (cfg_addr_t'(cfg_addr))
                    REG_GAIN_P: gain_p  = cfg_wdata[GAIN_W-1:0];
                    REG_GAIN_I: gain_i  = cfg_wdata[GAIN_W-1:0];
                    REG_GAIN_D: gain_d  = cfg_wdata[GAIN_W-1:0];
                    REG_PCT:    max_pct = cfg_wdata[PCT_W-1:0];
                    REG_TMO:    tmo_ms  = cfg_wdata[TMO_W-1:0];
                    REG_DPI:    dpi     = cfg_wdata[DPI_W-1:0];
                    default:    ;
                endcase
            end

            if (s_tvalid && s_tready)
                motor_cmd_q.push_back(compute_drive_cmd(s_tuser, s_tdata[15:0],
                                                        s_tdata[35:16], s_tdata[55:36],
                                                        s_tdata[75:56], s_tdata[95:76],
                                                        s_tdata[127:96]));
            pending = motor_cmd_q.size();
        end
    end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// Top of the drive distance PID regression: clock, reset, register setup,
// item traffic with random idling, and the verdict. Depends on ddpid_pkg,
// ddpid_checker and drive_distance_pid_with_settle_top.
module testbench;
    import ddpid_pkg::*;

    localparam int     ITEM_TARGET  = 1450;
    localparam int     PHASE_ITEMS  = 110;
    localparam int     PRESS_CYCLES = 300;
    localparam longint CYCLE_LIMIT  = 1000000;

    localparam logic signed [POS_W-1:0] POS_MAX = 20'sh7FFFF;
    localparam logic signed [POS_W-1:0] POS_MIN = 20'sh80000;
    localparam logic signed [TIN_W-1:0] TIN_MAX = 16'sh7FFF;
    localparam logic signed [TIN_W-1:0] TIN_MIN = 16'sh8000;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_W-1:0]      cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;

    int                fail_count;
    int                pending;
    int                sent;
    longint            cycles;
    logic [TIME_W-1:0] clock_ms;
    logic [DPI_W-1:0]  cur_dpi;
    bit                sender_quiet;
    bit                sink_quiet;
    bit                press;

    drive_distance_pid_with_settle_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    ddpid_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic int idle_len(input bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int jitter(input int span);
        int v;
        v = $urandom_range(0, 2 * span);
        return v - span;
    endfunction

    function automatic logic signed [POS_W-1:0] extreme_pos();
        return $urandom_range(0, 1) ? POS_MAX : POS_MIN;
    endfunction

    task automatic send_item(
        input logic                    cmd,
        input logic signed [TIN_W-1:0] tin,
        input logic signed [POS_W-1:0] p0,
        input logic signed [POS_W-1:0] p1,
        input logic signed [POS_W-1:0] p2,
        input logic signed [POS_W-1:0] p3,
        input logic [TIME_W-1:0]       now
    );
        int gap;
        gap = idle_len(sender_quiet);
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {now, p3, p2, p1, p0, tin};
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        sent++;
    endtask

    task automatic wait_idle(input int settle);
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (settle) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_addr_t addr, input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (addr == REG_DPI)
            cur_dpi = val[DPI_W-1:0];
    endtask

    task automatic apply_phase(input int p);
        logic [GAIN_W-1:0] gp;
        logic [GAIN_W-1:0] gi;
        logic [GAIN_W-1:0] gd;
        logic [PCT_W-1:0]  pct;
        logic [TMO_W-1:0]  tmo;
        logic [DPI_W-1:0]  dpi;
        int                r;
        case (p)
            0:
            begin
                gp  = '1;
                gi  = '1;
                gd  = '1;
                pct = '1;
                tmo = '1;
                dpi = '1;
            end
            1:
            begin
                gp  = '0;
                gi  = '0;
                gd  = '0;
                pct = '0;
                tmo = '0;
                dpi = 16'd1;
            end
            2:
            begin
                gp  = GAIN_P_RST;
                gi  = 24'd2000;
                gd  = GAIN_D_RST;
                pct = PCT_RST;
                tmo = TMO_RST;
                dpi = DPI_RST;
            end
            default:
            begin
                if ($urandom_range(0, 99) < 70)
                begin
                    gp = GAIN_W'($urandom_range(0, 24'h200000));
                    gi = GAIN_W'($urandom_range(0, 24'h004000));
                    gd = GAIN_W'($urandom_range(0, 24'h200000));
                end
                else
                begin
                    gp = GAIN_W'($urandom);
                    gi = GAIN_W'($urandom);
                    gd = GAIN_W'($urandom);
                end
                pct = PCT_W'($urandom_range(0, 127));
                r   = $urandom_range(0, 99);
                if (r < 10)
                    tmo = '0;
                else if (r < 20)
                    tmo = '1;
                else if (r < 35)
                    tmo = TMO_RST;
                else
                    tmo = TMO_W'($urandom_range(40, 600));
                if ($urandom_range(0, 99) < 80)
                    dpi = DPI_W'($urandom_range(2000, 20000));
                else
                    dpi = DPI_W'($urandom_range(1, 65535));
            end
        endcase
        write_reg(REG_GAIN_P, gp);
        write_reg(REG_GAIN_I, gi);
        write_reg(REG_GAIN_D, gd);
        write_reg(REG_PCT, CFG_W'(pct));
        write_reg(REG_TMO, CFG_W'(tmo));
        write_reg(REG_DPI, CFG_W'(dpi));
    endtask

    task automatic run_directed();
        send_item(CMD_SAMPLE, 16'sd0, POS_MAX, POS_MAX, POS_MAX, POS_MAX, 32'd0);
        send_item(CMD_START, TIN_MAX, -20'sd1, -20'sd1, -20'sd1, -20'sd1, 32'hFFFF_FF00);
        send_item(CMD_SAMPLE, 16'sd0, POS_MIN, POS_MIN, POS_MIN, POS_MIN, 32'hFFFF_FF10);
        send_item(CMD_SAMPLE, 16'sd0, POS_MAX, POS_MAX, POS_MAX, POS_MAX, 32'h0000_0020);
        // restart in the middle of a move
        send_item(CMD_START, TIN_MIN, 20'sd0, 20'sd0, 20'sd0, 20'sd0, 32'd1000);
        send_item(CMD_SAMPLE, 16'sd0, 20'sd0, 20'sd0, 20'sd0, 20'sd0, 32'd1010);
        // on target from the start: settles on the third sample
        send_item(CMD_START, 16'sd0, 20'sd0, 20'sd0, 20'sd0, 20'sd0, 32'd2000);
        send_item(CMD_SAMPLE, 16'sd0, 20'sd0, 20'sd0, 20'sd0, 20'sd0, 32'd2010);
        send_item(CMD_SAMPLE, 16'sd0, 20'sd0, 20'sd0, 20'sd0, 20'sd0, 32'd2020);
        send_item(CMD_SAMPLE, 16'sd0, 20'sd0, 20'sd0, 20'sd0, 20'sd0, 32'd2030);
        send_item(CMD_SAMPLE, 16'sd0, 20'sd0, 20'sd0, 20'sd0, 20'sd0, 32'd2040);
        // timeout far from target
        send_item(CMD_START, 16'sd256, 20'sd0, 20'sd0, 20'sd0, 20'sd0, 32'd5000);
        send_item(CMD_SAMPLE, 16'sd0, 20'sd10, 20'sd10, 20'sd10, 20'sd10, 32'd5020);
        send_item(CMD_SAMPLE, 16'sd0, 20'sd10, 20'sd10, 20'sd10, 20'sd10, 32'd8000);
        // settle and timeout on the same sample
        send_item(CMD_START, 16'sd0, 20'sd0, 20'sd0, 20'sd0, 20'sd0, 32'd9000);
        send_item(CMD_SAMPLE, 16'sd0, 20'sd0, 20'sd0, 20'sd0, 20'sd0, 32'd9010);
        send_item(CMD_SAMPLE, 16'sd0, 20'sd0, 20'sd0, 20'sd0, 20'sd0, 32'd9020);
        send_item(CMD_SAMPLE, 16'sd0, 20'sd0, 20'sd0, 20'sd0, 20'sd0, 32'd12000);
        // not moved yet, then moved by elapsed time only
        send_item(CMD_START, 16'sd64, 20'sd0, 20'sd0, 20'sd0, 20'sd0, 32'd20000);
        send_item(CMD_SAMPLE, 16'sd0, 20'sd3, 20'sd3, 20'sd3, 20'sd3, 32'd20010);
        send_item(CMD_SAMPLE, 16'sd0, 20'sd0, 20'sd0, 20'sd0, 20'sd0, 32'd20020);
        send_item(CMD_SAMPLE, 16'sd0, 20'sd3, 20'sd3, 20'sd3, 20'sd3, 32'd20200);
        // two more samples away from the target keep the settle count at zero
        send_item(CMD_SAMPLE, 16'sd0, 20'sd3, 20'sd3, 20'sd3, 20'sd4, 32'd20220);
        send_item(CMD_SAMPLE, 16'sd0, 20'sd25, 20'sd25, 20'sd25, 20'sd25, 32'd20240);
    endtask

    task automatic run_move();
        logic signed [TIN_W-1:0] tin;
        logic signed [POS_W-1:0] w0;
        logic signed [POS_W-1:0] w1;
        logic signed [POS_W-1:0] w2;
        logic signed [POS_W-1:0] w3;
        longint                  tgt;
        longint                  cur;
        int                      r;
        int                      n;
        int                      noise;
        int                      lag;
        r = $urandom_range(0, 99);
        if (r < 20)
            tin = TIN_W'($urandom);
        else if (r < 40)
            tin = TIN_W'(jitter(256));
        else
            tin = TIN_W'(jitter(6144));
        tgt   = (longint'(tin) * longint'(cur_dpi)) >>> 14;
        n     = $urandom_range(1, 30);
        noise = ($urandom_range(0, 99) < 50) ? 0 : $urandom_range(1, 40);
        lag   = $urandom_range(0, 3);
        clock_ms = clock_ms + $urandom_range(1, 50);
        send_item(CMD_START, tin, POS_W'($urandom), POS_W'($urandom), POS_W'($urandom),
                  POS_W'($urandom), clock_ms);
        cur = 0;
        for (int i = 0; i < n; i++)
        begin
            clock_ms = clock_ms + $urandom_range(5, 40);
            if (i >= lag)
                cur = cur + (tgt - cur) / 2;
            if (noise > 0)
                cur = cur + jitter(noise);
            w0 = POS_W'(cur / 4 + jitter(3));
            w1 = POS_W'(cur / 4 + jitter(3));
            w2 = POS_W'(cur / 4 + jitter(3));
            w3 = POS_W'(cur - w0 - w1 - w2);
            send_item(CMD_SAMPLE, TIN_W'($urandom), w0, w1, w2, w3, clock_ms);
        end
    endtask

    task automatic noise_item();
        case ($urandom_range(0, 3))
            0: send_item(CMD_SAMPLE, TIN_W'($urandom), POS_W'($urandom), POS_W'($urandom),
                         POS_W'($urandom), POS_W'($urandom), $urandom);
            1: send_item(CMD_START, TIN_W'($urandom), POS_W'($urandom), POS_W'($urandom),
                         POS_W'($urandom), POS_W'($urandom), clock_ms);
            2:
            begin
                clock_ms = $urandom;
                send_item(CMD_SAMPLE, TIN_W'($urandom), extreme_pos(), extreme_pos(),
                          extreme_pos(), extreme_pos(), clock_ms);
            end
            default: send_item(CMD_SAMPLE, TIN_W'($urandom), POS_W'(jitter(8)),
                               POS_W'(jitter(8)), POS_W'(jitter(8)), POS_W'(jitter(8)),
                               clock_ms + $urandom_range(0, 400));
        endcase
    endtask

    // result side: random stalls, plus one long hold-off during the pressure phase
    initial
    begin
        int run;
        int gap;
        bit held;
        m_tready = 1'b0;
        held     = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (press && !held)
            begin
                m_tready <= 1'b0;
                repeat (PRESS_CYCLES) @(negedge clk);
                held = 1'b1;
            end
            else
            begin
                run = $urandom_range(1, 12);
                m_tready <= 1'b1;
                repeat (run) @(negedge clk);
                gap = idle_len(sink_quiet);
                if (gap > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
        end
    end

    initial
    begin
        int p;
        int phase_end;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_addr     = '0;
        cfg_wdata    = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = 1'b0;
        sent         = 0;
        clock_ms     = '0;
        cur_dpi      = DPI_RST;
        sender_quiet = 1'b0;
        sink_quiet   = 1'b0;
        press        = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        run_directed();

        p = 0;
        while (sent < ITEM_TARGET)
        begin
            wait_idle(4);
            sender_quiet = (p == 2) || (p % 5 == 4);
            sink_quiet   = (p % 5 == 4);
            press        = (p == 2);
            apply_phase(p);
            clock_ms  = $urandom;
            phase_end = sent + PHASE_ITEMS;
            while (sent < phase_end && sent < ITEM_TARGET)
            begin
                if ($urandom_range(0, 99) < 15)
                    noise_item();
                else
                    run_move();
            end
            p++;
        end
        sender_quiet = 1'b0;
        sink_quiet   = 1'b0;

        wait_idle(20);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
